// ===== rtl/zsbf_pkg.sv =====
// Package with the shared types and constants of the zlib stored-block framer.
package zsbf_pkg;

    // Adler-32 modulus and the largest stored-block payload.
    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

    // zlib stream header bytes.
    localparam logic [7:0] ZLIB_CMF = 8'h78;
    localparam logic [7:0] ZLIB_FLG = 8'h01;

    // Byte value used for block-type fields and on overrun results.
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Input item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // Output byte slots, in stream order. One input item enables a subset of them.
    localparam int NUM_SLOTS = 13;

    typedef enum logic [3:0] {
        SLOT_HDR0   = 4'd0,
        SLOT_HDR1   = 4'd1,
        SLOT_BFINAL = 4'd2,
        SLOT_LEN_LO = 4'd3,
        SLOT_LEN_HI = 4'd4,
        SLOT_NLEN_LO = 4'd5,
        SLOT_NLEN_HI = 4'd6,
        SLOT_DATA   = 4'd7,
        SLOT_ADL3   = 4'd8,
        SLOT_ADL2   = 4'd9,
        SLOT_ADL1   = 4'd10,
        SLOT_ADL0   = 4'd11,
        SLOT_OVR    = 4'd12
    } slot_t;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // Everything the emitter needs to serialize the results of one transaction.
    typedef struct packed {
        slot_mask_t  mask;
        logic [15:0] block_len;
        logic        block_final;
        logic [7:0]  data_byte;
        logic [31:0] adler;
    } burst_t;

    // Emitter status toward the framing core.
    typedef struct packed {
        logic take_ok;
        logic busy;
    } emit_status_t;

endpackage

// ===== rtl/zsbf_if.sv =====
// Handshake channel interfaces for input items and result bytes.
interface zsbf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface zsbf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       overrun;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    output overrun, input ready);
    modport sink (input valid, input out_byte, input run_last, input stream_end,
                  input overrun, output ready);
endinterface

// ===== rtl/zsbf_core.sv =====
// Framing core: stream state, Adler-32 update and per-transaction burst build.
module zsbf_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_data,
    zsbf_in_if.sink               item,
    input  zsbf_pkg::emit_status_t status,
    output logic                  accept,
    output zsbf_pkg::burst_t      burst
);
    import zsbf_pkg::*;

    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] bytes_taken_reg, bytes_taken_next;
    logic [15:0]            block_left_reg, block_left_next;
    logic [15:0]            sum_low_reg, sum_low_next;
    logic [15:0]            sum_high_reg, sum_high_next;

    logic [LENGTH_BITS-1:0] remain;
    logic [LENGTH_BITS-1:0] taken_inc;
    logic                   remain_big;
    logic [15:0]            new_len;
    logic [16:0]            low_sum;
    logic [16:0]            high_sum;
    logic [15:0]            low_mod;
    logic [15:0]            high_mod;

    assign item.ready = status.take_ok;
    assign accept     = item.valid && status.take_ok;

    // Length register, to be written only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_we)
        begin
            len_reg <= LENGTH_BITS'(cfg_data);
        end
    end

    // Adler-32 sums with a single conditional subtract each.
    always_comb
    begin
        low_sum  = {1'b0, sum_low_reg} + {9'b0, item.data_byte};
        low_mod  = (low_sum >= {1'b0, ADLER_MOD}) ? 16'(low_sum - {1'b0, ADLER_MOD})
                                                  : low_sum[15:0];
        high_sum = {1'b0, sum_high_reg} + {1'b0, low_mod};
        high_mod = (high_sum >= {1'b0, ADLER_MOD}) ? 16'(high_sum - {1'b0, ADLER_MOD})
                                                   : high_sum[15:0];
    end

    // Block sizing from what remains of the stream.
    always_comb
    begin
        remain     = len_reg - bytes_taken_reg;
        remain_big = |remain[LENGTH_BITS-1:16];
        new_len    = remain_big ? BLOCK_MAX : remain[15:0];
        taken_inc  = bytes_taken_reg + LENGTH_BITS'(1);
    end

    // Next state and the burst of result slots for the offered transaction.
    always_comb
    begin
        bytes_taken_next  = bytes_taken_reg;
        block_left_next   = block_left_reg;
        sum_low_next      = sum_low_reg;
        sum_high_next     = sum_high_reg;
        burst.mask        = '0;
        burst.block_len   = 16'd0;
        burst.block_final = 1'b1;
        burst.data_byte   = item.data_byte;
        burst.adler       = {sum_high_reg, sum_low_reg};

        if (item.kind == KIND_START)
        begin
            // A start restarts the stream; an empty stream closes at once.
            bytes_taken_next = '0;
            block_left_next  = 16'd0;
            sum_low_next     = 16'd1;
            sum_high_next    = 16'd0;
            burst.adler      = 32'h0000_0001;
            burst.mask[SLOT_HDR0] = 1'b1;
            burst.mask[SLOT_HDR1] = 1'b1;
            if (len_reg == '0)
            begin
                burst.mask[SLOT_BFINAL]  = 1'b1;
                burst.mask[SLOT_LEN_LO]  = 1'b1;
                burst.mask[SLOT_LEN_HI]  = 1'b1;
                burst.mask[SLOT_NLEN_LO] = 1'b1;
                burst.mask[SLOT_NLEN_HI] = 1'b1;
                burst.mask[SLOT_ADL3]    = 1'b1;
                burst.mask[SLOT_ADL2]    = 1'b1;
                burst.mask[SLOT_ADL1]    = 1'b1;
                burst.mask[SLOT_ADL0]    = 1'b1;
            end
        end
        else if (bytes_taken_reg >= len_reg)
        begin
            burst.mask[SLOT_OVR] = 1'b1;
        end
        else
        begin
            // Pass the byte through, opening a new stored block when needed.
            burst.mask[SLOT_DATA] = 1'b1;
            burst.block_len       = new_len;
            burst.block_final     = !remain_big;
            if (block_left_reg == 16'd0)
            begin
                burst.mask[SLOT_BFINAL]  = 1'b1;
                burst.mask[SLOT_LEN_LO]  = 1'b1;
                burst.mask[SLOT_LEN_HI]  = 1'b1;
                burst.mask[SLOT_NLEN_LO] = 1'b1;
                burst.mask[SLOT_NLEN_HI] = 1'b1;
                block_left_next = new_len - 16'd1;
            end
            else
            begin
                block_left_next = block_left_reg - 16'd1;
            end
            bytes_taken_next = taken_inc;
            sum_low_next     = low_mod;
            sum_high_next    = high_mod;
            burst.adler      = {high_mod, low_mod};
            if (taken_inc == len_reg)
            begin
                burst.mask[SLOT_ADL3] = 1'b1;
                burst.mask[SLOT_ADL2] = 1'b1;
                burst.mask[SLOT_ADL1] = 1'b1;
                burst.mask[SLOT_ADL0] = 1'b1;
            end
        end
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg <= '0;
            block_left_reg  <= 16'd0;
            sum_low_reg     <= 16'd1;
            sum_high_reg    <= 16'd0;
        end
        else if (accept)
        begin
            bytes_taken_reg <= bytes_taken_next;
            block_left_reg  <= block_left_next;
            sum_low_reg     <= sum_low_next;
            sum_high_reg    <= sum_high_next;
        end
    end

endmodule

// ===== rtl/zsbf_emitter.sv =====
// Burst register and output register: serializes one transaction's result bytes.
module zsbf_emitter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  zsbf_pkg::burst_t        burst,
    output zsbf_pkg::emit_status_t  status,
    zsbf_out_if.source              result
);
    import zsbf_pkg::*;

    slot_mask_t  mask_reg, mask_next;
    logic [15:0] block_len_reg;
    logic        block_final_reg;
    logic [7:0]  data_byte_reg;
    logic [31:0] adler_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg;
    logic        stream_end_reg;
    logic        overrun_reg;

    logic        out_load;
    logic        single;
    logic [3:0]  slot_idx;
    logic [7:0]  slot_byte;

    // The lowest pending slot goes out next.
    always_comb
    begin
        slot_idx = 4'd0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                slot_idx = 4'(i);
            end
        end
    end

    // Byte for the current slot.
    always_comb
    begin
        unique case (slot_t'(slot_idx))
            SLOT_HDR0:    slot_byte = ZLIB_CMF;
            SLOT_HDR1:    slot_byte = ZLIB_FLG;
            SLOT_BFINAL:  slot_byte = {7'd0, block_final_reg};
            SLOT_LEN_LO:  slot_byte = block_len_reg[7:0];
            SLOT_LEN_HI:  slot_byte = block_len_reg[15:8];
            SLOT_NLEN_LO: slot_byte = ~block_len_reg[7:0];
            SLOT_NLEN_HI: slot_byte = ~block_len_reg[15:8];
            SLOT_DATA:    slot_byte = data_byte_reg;
            SLOT_ADL3:    slot_byte = adler_reg[31:24];
            SLOT_ADL2:    slot_byte = adler_reg[23:16];
            SLOT_ADL1:    slot_byte = adler_reg[15:8];
            SLOT_ADL0:    slot_byte = adler_reg[7:0];
            SLOT_OVR:     slot_byte = BYTE_ZERO;
            default:      slot_byte = BYTE_ZERO;
        endcase
    end

    // Handshake between the burst register and the output register.
    always_comb
    begin
        single         = (mask_reg != '0) &&
                         ((mask_reg & (mask_reg - slot_mask_t'(1))) == '0);
        out_load       = (mask_reg != '0) && (!out_valid_reg || result.ready);
        status.busy    = (mask_reg != '0);
        status.take_ok = (mask_reg == '0) || (single && out_load);

        mask_next = mask_reg;
        if (accept)
        begin
            mask_next = burst.mask;
        end
        else if (out_load)
        begin
            mask_next = mask_reg & (mask_reg - slot_mask_t'(1));
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Burst payload, captured with each transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            block_len_reg   <= burst.block_len;
            block_final_reg <= burst.block_final;
            data_byte_reg   <= burst.data_byte;
            adler_reg       <= burst.adler;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg   <= slot_byte;
            run_last_reg   <= single;
            stream_end_reg <= (slot_t'(slot_idx) == SLOT_ADL0);
            overrun_reg    <= (slot_t'(slot_idx) == SLOT_OVR);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.run_last   = run_last_reg;
    assign result.stream_end = stream_end_reg;
    assign result.overrun    = overrun_reg;

endmodule

// ===== rtl/zlib_stored_block_framer_unit.sv =====
// Top level of the zlib stored-block framer with Adler-32 trailer.
//
//  Channel   Direction  Payload                                     Handshake
//  item      in         kind, data_byte                             valid/ready
//  result    out        out_byte, run_last, stream_end, overrun     valid/ready
//  cfg       in         cfg_data (stream_length)                    cfg_we
//
// A data byte inside a running block gives a single result byte, so one byte per clock streams
// through while result.ready stays high. A transaction that opens a block or closes the stream
// holds item.ready low while its burst register holds more than one result byte (up to ten extra
// bytes). A result passes through the burst register and then the output register.
// Reset clears the stream state and the length; result.ready low stalls the output
// register, and the input stalls while the burst register holds more than one byte,
// or holds its last byte while the output register is full and not taken.
module zlib_stored_block_framer_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    zsbf_in_if.sink     item,
    zsbf_out_if.source  result
);
    import zsbf_pkg::*;

    logic         accept;
    burst_t       burst;
    emit_status_t status;

    // Stream state and burst build.
    zsbf_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .status   (status),
        .accept   (accept),
        .burst    (burst)
    );

    // Result serializer.
    zsbf_emitter u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .burst  (burst),
        .status (status),
        .result (result)
    );

    // A taken transaction always leaves bytes to send.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> status.busy)
        else $error("burst register empty after a transaction");

    // An idle emitter always takes input.
    assert property (@(posedge clk) disable iff (!rst_n) !status.busy |-> item.ready)
        else $error("input stalled while the emitter is idle");

    // The closing trailer byte ends its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.stream_end) |-> result.run_last)
        else $error("stream end not on the last result of a transaction");

    // An overrun result is a lone zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.overrun) |-> (result.run_last && result.out_byte == 8'h00))
        else $error("malformed overrun result");

endmodule

// ===== tb/sv/zlib_stored_block_framer_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the zlib stored-block framer: random handshakes and a byte predictor.
module zlib_stored_block_framer_unit_test;

    import zsbf_pkg::*;

    // Block-type byte of a stored-block header.
    localparam logic [7:0] BFINAL_LAST = 8'h01;
    localparam logic [7:0] BFINAL_MORE = BYTE_ZERO;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 350;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 16;

    // One input transaction waiting to be sent; hold_for_drain pauses the sender
    // until every expected result byte has arrived.
    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        bit         hold_for_drain;
    } frame_item_t;

    // One byte of the zlib stream with its flags.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
        logic       overrun;
    } zbyte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;

    zsbf_in_if  item_ch ();
    zsbf_out_if result_ch ();

    zlib_stored_block_framer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    // Predictor copy of the length register and the stream state.
    logic [31:0] stream_len;
    logic [31:0] taken;
    logic [15:0] block_left;
    logic [15:0] sum_lo;
    logic [15:0] sum_hi;

    frame_item_t item_backlog[$];
    zbyte_t      stream_bytes_due[$];

    int  item_total;
    int  bad_bytes;
    int  quiet_cycles;
    int  send_gap;
    int  send_calm;
    int  recv_gap;
    int  recv_calm;
    bit  in_fire;
    bit  out_fire;

    always #10 clk = ~clk;

    // Gap lengths: mostly none or short, a few long, and now and then a calm stretch.
    function automatic int draw_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic fin, input logic ovr);
        zbyte_t z;
        z = '{b, 1'b0, fin, ovr};
        stream_bytes_due.push_back(z);
    endfunction

    function automatic void add_block_header(input logic [15:0] n, input logic final_block);
        add_byte(final_block ? BFINAL_LAST : BFINAL_MORE, 1'b0, 1'b0);
        add_byte(n[7:0], 1'b0, 1'b0);
        add_byte(n[15:8], 1'b0, 1'b0);
        add_byte(~n[7:0], 1'b0, 1'b0);
        add_byte(~n[15:8], 1'b0, 1'b0);
    endfunction

    // The Adler-32 trailer goes out most significant byte first.
    function automatic void add_adler();
        logic [31:0] word;
        word = {sum_hi, sum_lo};
        add_byte(word[31:24], 1'b0, 1'b0);
        add_byte(word[23:16], 1'b0, 1'b0);
        add_byte(word[15:8], 1'b0, 1'b0);
        add_byte(word[7:0], 1'b1, 1'b0);
    endfunction

    // Works out the zlib bytes that one accepted transaction produces.
    function automatic void frame_item(input logic kind, input logic [7:0] dbyte);
        logic [31:0] rem;
        logic [15:0] n;
        zbyte_t      tail;
        if (kind == KIND_START)
        begin
            taken      = '0;
            block_left = '0;
            sum_lo     = 16'd1;
            sum_hi     = '0;
            add_byte(ZLIB_CMF, 1'b0, 1'b0);
            add_byte(ZLIB_FLG, 1'b0, 1'b0);
            if (stream_len == 0)
            begin
                add_block_header(16'd0, 1'b1);
                add_adler();
            end
        end
        else if (taken >= stream_len)
        begin
            add_byte(BYTE_ZERO, 1'b0, 1'b1);
        end
        else
        begin
            // A new stored block opens, sized from what is left of the stream.
            if (block_left == 0)
            begin
                rem = stream_len - taken;
                n = (rem > 32'(BLOCK_MAX)) ? BLOCK_MAX : rem[15:0];
                add_block_header(n, rem <= 32'(BLOCK_MAX));
                block_left = n;
            end
            add_byte(dbyte, 1'b0, 1'b0);
            block_left = block_left - 16'd1;
            taken      = taken + 32'd1;
            sum_lo = 16'((int'(sum_lo) + int'(dbyte)) % int'(ADLER_MOD));
            sum_hi = 16'((int'(sum_hi) + int'(sum_lo)) % int'(ADLER_MOD));
            if (taken == stream_len)
                add_adler();
        end
        tail = stream_bytes_due.pop_back();
        tail.run_last = 1'b1;
        stream_bytes_due.push_back(tail);
    endfunction

    // Input driver: a new transaction or a gap at each falling edge.
    always @(negedge clk)
    begin : item_driver
        frame_item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else if (item_ch.valid && !in_fire)
        begin
            // The current transaction is still waiting for ready.
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            item_ch.valid <= 1'b0;
        end
        else if (item_backlog.size() > 0 &&
                 (!item_backlog[0].hold_for_drain || stream_bytes_due.size() == 0))
        begin
            nxt = item_backlog.pop_front();
            item_ch.valid     <= 1'b1;
            item_ch.kind      <= nxt.kind;
            item_ch.data_byte <= nxt.data_byte;
            send_gap = draw_gap(send_calm);
        end
        else
        begin
            item_ch.valid <= 1'b0;
        end
    end

    // Result sink: ready drops for a random gap after each accepted byte.
    always @(negedge clk)
    begin : result_sink
        int gap;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (out_fire)
        begin
            gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                recv_gap = gap - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Monitor: checks each result byte against the oldest expectation and
    // predicts the bytes of each accepted input transaction.
    always @(posedge clk)
    begin : monitor
        zbyte_t got;
        zbyte_t want;
        bit     took_item;
        bit     took_byte;
        took_item = rst_n && item_ch.valid && item_ch.ready;
        took_byte = rst_n && result_ch.valid && result_ch.ready;
        in_fire  <= took_item;
        out_fire <= took_byte;
        if (took_byte)
        begin
            got = '{result_ch.out_byte, result_ch.run_last, result_ch.stream_end,
                    result_ch.overrun};
            if (stream_bytes_due.size() == 0)
            begin
                bad_bytes++;
                $display("%0t: unexpected result: byte %h last %b end %b overrun %b",
                         $time, got.out_byte, got.run_last, got.stream_end, got.overrun);
            end
            else
            begin
                want = stream_bytes_due.pop_front();
                if (got !== want)
                begin
                    // Fields are byte/last/end/overrun.
                    bad_bytes++;
                    $display("%0t: mismatch: expected %h/%b/%b/%b, actual %h/%b/%b/%b",
                             $time, want.out_byte, want.run_last, want.stream_end,
                             want.overrun, got.out_byte, got.run_last, got.stream_end,
                             got.overrun);
                end
            end
        end
        if (took_item)
            frame_item(item_ch.kind, item_ch.data_byte);
        if (took_item || took_byte)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit hold_roll();
        return $urandom_range(0, 49) == 0;
    endfunction

    task automatic queue_item(input logic kind, input logic [7:0] b, input bit hold);
        frame_item_t it;
        it = '{kind, b, hold};
        item_backlog.push_back(it);
        item_total++;
    endtask

    // Waits until every queued transaction is taken and every result has arrived.
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || item_ch.valid || stream_bytes_due.size() != 0);
    endtask

    // Writes the stream length while the block is idle.
    task automatic set_length(input logic [31:0] len);
        wait_quiet();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(negedge clk);
        cfg_we   <= 1'b0;
        stream_len = len;
    endtask

    initial
    begin : stimulus
        logic [31:0] len;
        int          pick;
        int          count;
        int          extra;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_START;
        item_ch.data_byte   = '0;
        result_ch.ready     = 1'b0;
        stream_len          = '0;
        taken               = '0;
        block_left          = '0;
        sum_lo              = 16'd1;
        sum_hi              = '0;
        item_total          = 0;
        bad_bytes           = 0;
        quiet_cycles        = 0;
        send_gap            = 0;
        send_calm           = 0;
        recv_gap            = 0;
        recv_calm           = 0;
        in_fire             = 1'b0;
        out_fire            = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Data before any start with the reset length is an overrun.
        queue_item(KIND_DATA, 8'h00, 1'b0);

        // Data before any start frames from the reset state, then overruns.
        set_length(32'd2);
        queue_item(KIND_DATA, 8'hFF, 1'b0);
        queue_item(KIND_DATA, 8'h00, 1'b0);
        queue_item(KIND_DATA, 8'h11, 1'b0);

        // A zero-length stream: header, empty final block and trailer on start.
        set_length(32'd0);
        queue_item(KIND_START, 8'hFF, 1'b0);
        queue_item(KIND_DATA, 8'h5A, 1'b0);

        // One-byte stream.
        set_length(32'd1);
        queue_item(KIND_START, 8'h00, 1'b0);
        queue_item(KIND_DATA, 8'hFF, 1'b0);

        // Length raised after the stream ended: a second final block follows.
        set_length(32'd3);
        queue_item(KIND_DATA, 8'h80, 1'b0);
        queue_item(KIND_DATA, 8'h7F, 1'b0);

        // Largest length: a full non-final block opens.
        set_length(32'hFFFF_FFFF);
        queue_item(KIND_START, 8'h00, 1'b0);
        queue_item(KIND_DATA, 8'hA5, 1'b0);
        queue_item(KIND_DATA, 8'h3C, 1'b0);

        // Length cut inside a block: the trailer comes mid-block; then the length
        // grows and the rest of the old block runs out before a new header.
        set_length(32'd10);
        queue_item(KIND_START, 8'h00, 1'b0);
        queue_item(KIND_DATA, 8'h01, 1'b0);
        queue_item(KIND_DATA, 8'h02, 1'b0);
        queue_item(KIND_DATA, 8'h03, 1'b0);
        set_length(32'd5);
        queue_item(KIND_DATA, 8'h04, 1'b0);
        queue_item(KIND_DATA, 8'h05, 1'b1);
        set_length(32'd100);
        for (int i = 6; i < 12; i++)
            queue_item(KIND_DATA, 8'(i), 1'b0);

        // Random phases, mostly well-formed streams of random content.
        while (item_total < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = '0;
            else if (pick < 65)
                len = $urandom_range(1, 24);
            else if (pick < 80)
                len = $urandom_range(25, 90);
            else if (pick < 87)
                len = $urandom_range(65533, 65537);
            else if (pick < 94)
                len = $urandom;
            else
                len = 32'hFFFF_FFFF - $urandom_range(0, 2);
            set_length(len);
            if ($urandom_range(0, 99) < 85)
            begin
                // A start and the stream's bytes, at times cut short, broken by a
                // restart, or followed by bytes past the end.
                count = (len <= 90) ? int'(len) : $urandom_range(1, 10);
                if (count > 0 && $urandom_range(0, 9) == 0)
                    count = $urandom_range(0, count - 1);
                if ($urandom_range(0, 9) != 0)
                    queue_item(KIND_START, 8'($urandom), hold_roll());
                for (int i = 0; i < count; i++)
                begin
                    if ($urandom_range(0, 99) < 3)
                        queue_item(KIND_START, 8'($urandom), hold_roll());
                    queue_item(KIND_DATA, 8'($urandom), hold_roll());
                end
                extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                repeat (extra)
                    queue_item(KIND_DATA, 8'($urandom), hold_roll());
            end
            else
            begin
                // Noise: the old stream goes on under the new length, mixed with restarts.
                count = $urandom_range(1, 12);
                repeat (count)
                    queue_item(($urandom_range(0, 6) == 0) ? KIND_START : KIND_DATA,
                               8'($urandom), hold_roll());
            end
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_bytes == 0 && stream_bytes_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
